// ===== hw/rtl/dthad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dthad_pkg;

  // Fixed field widths
  localparam int unsigned TempW    = 48;
  localparam int unsigned AgeInW   = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned DecayW   = 24;
  localparam int unsigned GainW    = 32;
  localparam int unsigned ChunkW   = 24;  // temperature is scaled in two halves of this width
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_DECAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLD  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOT   = 2'd3;

  // Register reset values
  localparam logic [DecayW-1:0] DecayRst = 24'd15099494;
  localparam logic [GainW-1:0]  GainRst  = 32'd167772160;
  localparam logic [TempW-1:0]  ColdRst  = 48'd16777;
  localparam logic [TempW-1:0]  HotRst   = 48'd16777216;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIRST,
    ST_POW,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_SUM,
    ST_COLD,
    ST_ADD,
    ST_UPDATE,
    ST_PUBLISH
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,          // latch input word
    OP_FIRST,         // gain * count, clear record state
    OP_POW_INIT_GAP,  // power unit: exponent gap - 1
    OP_POW_MUL,       // acc <= acc * base
    OP_POW_SQ,        // base <= base * base
    OP_SC_LO,         // low half of temperature times power
    OP_SC_HI,         // high half of temperature times power
    OP_SC_SUM,        // combine halves into temperature
    OP_COLD_NEXT,     // cold check, power unit: exponent one
    OP_ADD,           // saturating add of count
    OP_UPDATE,        // peak / hot-again update
    OP_PUBLISH        // load output register
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic rising;
    logic exp_zero;
    logic exp_lsb;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dthad_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dthad_ctrl
  import dthad_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   pass_q, pass_d;       // 0: decay by alpha^(gap-1), 1: decay by alpha
  logic   out_valid_q, out_valid_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.first) begin
          state_d = ST_FIRST;
        end else if (!status_i.rising) begin
          state_d = ST_ADD;
        end else begin
          cmd_o.op = OP_POW_INIT_GAP;
          pass_d   = 1'b0;
          state_d  = ST_POW;
        end
      end
      ST_FIRST: begin
        cmd_o.op = OP_FIRST;
        state_d  = ST_PUBLISH;
      end
      // square-and-multiply, lsb first, stops once the exponent is spent
      ST_POW: begin
        if (status_i.exp_zero) begin
          state_d = ST_SC_LO;
        end else if (status_i.exp_lsb) begin
          cmd_o.op = OP_POW_MUL;
        end else begin
          cmd_o.op = OP_POW_SQ;
        end
      end
      ST_SC_LO: begin
        cmd_o.op = OP_SC_LO;
        state_d  = ST_SC_HI;
      end
      ST_SC_HI: begin
        cmd_o.op = OP_SC_HI;
        state_d  = ST_SC_SUM;
      end
      ST_SC_SUM: begin
        cmd_o.op = OP_SC_SUM;
        state_d  = pass_q ? ST_ADD : ST_COLD;
      end
      ST_COLD: begin
        cmd_o.op = OP_COLD_NEXT;
        pass_d   = 1'b1;
        state_d  = ST_POW;
      end
      ST_ADD: begin
        cmd_o.op = OP_ADD;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = ST_PUBLISH;
      end
      // wait for the output register to be free
      ST_PUBLISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dthad_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dthad_datapath
  import dthad_pkg::*;
#(
  parameter int unsigned AGE_BITS  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_status_t               status_o,
  // input word
  input  wire logic                first_pair_i,
  input  wire logic [AgeInW-1:0]   age_value_i,
  input  wire logic [CntW-1:0]     access_count_i,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // result word
  output logic [TempW-1:0]         temperature_o,
  output logic                     peak_passed_o,
  output logic [TempW-1:0]         peak_temperature_o,
  output logic                     hot_again_o
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned AW  = (AGE_BITS < AgeInW) ? AGE_BITS : AgeInW;
  localparam int unsigned XW  = GainW;                       // covers base, chunk and gain
  localparam int unsigned YW  = (F + 1 > CntW) ? F + 1 : CntW;
  localparam int unsigned PW  = XW + YW;
  localparam int unsigned LW  = ChunkW + F + 1;              // one half-product
  localparam int unsigned SW  = TempW + F + 1;               // recombined product
  localparam int unsigned AXW = DecayW + GainW;              // alpha, widened for masking

  // Configuration registers
  logic [DecayW-1:0] decay_q;
  logic [GainW-1:0]  gain_q;
  logic [TempW-1:0]  cold_thr_q;
  logic [TempW-1:0]  hot_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q    <= DecayRst;
      gain_q     <= GainRst;
      cold_thr_q <= ColdRst;
      hot_thr_q  <= HotRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DECAY: decay_q    <= cfg_data_i[DecayW-1:0];
        CFG_GAIN:  gain_q     <= cfg_data_i[GainW-1:0];
        CFG_COLD:  cold_thr_q <= cfg_data_i[TempW-1:0];
        CFG_HOT:   hot_thr_q  <= cfg_data_i[TempW-1:0];
        default: ;
      endcase
    end
  end

  // Latched input word
  logic            first_q;
  logic [AW-1:0]   age_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      first_q <= first_pair_i;
      age_q   <= age_value_i[AW-1:0];
      cnt_q   <= access_count_i;
    end
  end

  // Record state
  logic [TempW-1:0] temp_q;
  logic [AW-1:0]    prev_q;
  logic             cold_q;
  logic [TempW-1:0] peak_q;
  logic             hot_q;

  // Power unit and scaling scratch
  logic [F:0]    acc_q;
  logic [F-1:0]  base_q;
  logic [AW-1:0] exp_q;
  logic [LW-1:0] lo_q;
  logic [LW-1:0] hi_q;

  // alpha masked to the fraction bits
  logic [AXW-1:0] alpha_wide;
  logic [F-1:0]   alpha;
  logic [F:0]     one_fx;
  assign alpha_wide = AXW'(decay_q);
  assign alpha      = alpha_wide[F-1:0];
  assign one_fx     = {1'b1, {F{1'b0}}};

  // Shared multiplier, operand selection by operation
  logic [XW-1:0] mul_x;
  logic [YW-1:0] mul_y;
  logic [PW-1:0] prod;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd_i.op)
      OP_POW_MUL: begin
        mul_x = XW'(base_q);
        mul_y = YW'(acc_q);
      end
      OP_POW_SQ: begin
        mul_x = XW'(base_q);
        mul_y = YW'(base_q);
      end
      OP_SC_LO: begin
        mul_x = XW'(temp_q[ChunkW-1:0]);
        mul_y = YW'(acc_q);
      end
      OP_SC_HI: begin
        mul_x = XW'(temp_q[TempW-1:ChunkW]);
        mul_y = YW'(acc_q);
      end
      OP_FIRST: begin
        mul_x = gain_q;
        mul_y = YW'(cnt_q);
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_x) * PW'(mul_y);

  // Recombine half-products, floor to the fraction point
  logic [SW-1:0] sc_sum;
  assign sc_sum = (SW'(hi_q) << ChunkW) + SW'(lo_q);

  // Saturating count add
  logic [CntW+F-1:0] cnt_fx;
  logic [TempW:0]    add_sum;
  assign cnt_fx  = {cnt_q, {F{1'b0}}};
  assign add_sum = (TempW + 1)'(temp_q) + (TempW + 1)'(cnt_fx);

  // Age gap
  logic [AW-1:0] gap;
  assign gap = age_q - prev_q;

  // Record state and power unit updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      prev_q <= '0;
      cold_q <= 1'b0;
      peak_q <= '0;
      hot_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_FIRST: begin
          temp_q <= prod[TempW-1:0];
          prev_q <= age_q;
          cold_q <= 1'b0;
          peak_q <= '0;
          hot_q  <= 1'b0;
        end
        OP_SC_SUM: begin
          temp_q <= TempW'(sc_sum >> F);
        end
        OP_COLD_NEXT: begin
          if (!cold_q && (gap > AW'(1)) && (temp_q < cold_thr_q)) begin
            cold_q <= 1'b1;
          end
        end
        OP_ADD: begin
          temp_q <= add_sum[TempW] ? {TempW{1'b1}} : add_sum[TempW-1:0];
          prev_q <= age_q;
        end
        OP_UPDATE: begin
          if (!cold_q) begin
            if (temp_q > peak_q) begin
              peak_q <= temp_q;
            end
          end else if (temp_q > hot_thr_q) begin
            hot_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Power unit and scratch registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_POW_INIT_GAP: begin
        acc_q  <= one_fx;
        base_q <= alpha;
        exp_q  <= gap - AW'(1);
      end
      OP_COLD_NEXT: begin
        acc_q  <= one_fx;
        base_q <= alpha;
        exp_q  <= AW'(1);
      end
      OP_POW_MUL: begin
        acc_q    <= (F + 1)'(prod >> F);
        exp_q[0] <= 1'b0;
      end
      OP_POW_SQ: begin
        base_q <= F'(prod >> F);
        exp_q  <= exp_q >> 1;
      end
      OP_SC_LO: lo_q <= prod[LW-1:0];
      OP_SC_HI: hi_q <= prod[LW-1:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      temperature_o      <= temp_q;
      peak_passed_o      <= cold_q;
      peak_temperature_o <= peak_q;
      hot_again_o        <= hot_q;
    end
  end

  // Status to the controller
  assign status_o.first    = first_q;
  assign status_o.rising   = age_q > prev_q;
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/decaying_temperature_hot_again_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake               Word
// input    in_valid_i/in_ready_o   first_pair_i, age_value_i, access_count_i
// output   out_valid_o/out_ready_i temperature_o, peak_passed_o, peak_temperature_o,
//                                  hot_again_o
// config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word at a time. alpha^(gap-1) is built by square-and-multiply on the one shared
// multiplier, one product a cycle; a first pair or an age that is not rising skips it.
// Reset clears the record state and loads the register defaults. A result waiting
// in the output register does not stop the next word; that word holds in its last
// cycle until the waiting result is taken.

module decaying_temperature_hot_again_detector_unit
  import dthad_pkg::*;
#(
  parameter int unsigned AGE_BITS  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                first_pair_i,
  input  wire logic [AgeInW-1:0]   age_value_i,
  input  wire logic [CntW-1:0]     access_count_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [TempW-1:0]         temperature_o,
  output logic                     peak_passed_o,
  output logic [TempW-1:0]         peak_temperature_o,
  output logic                     hot_again_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  dthad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dthad_datapath #(
    .AGE_BITS  (AGE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .first_pair_i       (first_pair_i),
    .age_value_i        (age_value_i),
    .access_count_i     (access_count_i),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .temperature_o      (temperature_o),
    .peak_passed_o      (peak_passed_o),
    .peak_temperature_o (peak_temperature_o),
    .hot_again_o        (hot_again_o)
  );

endmodule

`default_nettype wire
